FILE: sv/wstu_pkg.sv
// Shared types and constants for the wire string to UTF-8 transcoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package wstu_pkg;

   // configuration register indexes
   localparam logic CSR_FORMAT_MODE = 1'b0;
   localparam logic CSR_MAX_UNITS   = 1'b1;

   localparam logic [15:0] MAX_UNITS_RESET = 16'd4096;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TRUNC    = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   // UTF-8 lead and continuation prefixes
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   localparam logic [20:0] REPLACEMENT_CHAR = 21'h00FFFD;
   localparam logic [31:0] CODE_POINT_LIMIT = 32'h0011_0000;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] bytes_left;
   } wstu_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic [1:0] status;
   } wstu_rsp_type;

   typedef struct packed {
      logic        format_mode;
      logic [15:0] max_units;
   } wstu_cfg_type;

   // one unit of back-end work: an optional character, then an optional end marker
   typedef struct packed {
      logic        has_char;
      logic [1:0]  len_m1;
      logic        term;
      logic [1:0]  status;
      logic [20:0] cp;
   } wstu_job_type;

endpackage

`default_nettype wire

FILE: sv/wire_string_to_utf8_top.sv
// Wire string to UTF-8 transcoder: top level with configuration registers.
// Depends on wstu_pkg, wstu_front, wstu_queue and wstu_back.
//
// Usage: feed the bytes of a length-prefixed string on req_ (valid/ready),
// each with the count of body bytes that follow it. Results leave on rsp_
// as UTF-8 bytes, closed by a zero byte with last set; a length error gives
// a single zero byte with last set and a nonzero status, and the next byte
// is read as a fresh count. csr_ writes format_mode (index 0) and max_units
// (index 1) in the cycle csr_we is high; write only while the block is idle.
// With the job queue empty, a byte that completes a character is written
// into the queue, and its first output byte is then registered into the
// result stage before it shows on rsp_. Throughput: one input byte per cycle
// while the job queue has room; the emitter sends one result per cycle while
// a job waits and rsp_ready is high. A character gives 1 to 4 bytes and each
// string end one terminator. When rsp_ready stays low the four-entry job
// queue fills and req_ready drops; nothing is lost. Reset returns the parser
// to await a count, empties the queue, sets format_mode 0, max_units 4096.
`default_nettype none

module wire_string_to_utf8_top #(
   parameter int MAX_BODY_BYTES = 65535
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire wstu_pkg::wstu_req_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output wstu_pkg::wstu_rsp_type      rsp_data,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [15:0]            csr_wdata
);
   import wstu_pkg::*;

   wstu_cfg_type cfg_ff, cfg_in;
   logic         take;
   logic         q_push, q_full, q_pop, q_valid;
   wstu_job_type q_job, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FORMAT_MODE: cfg_in.format_mode = csr_wdata[0];
            CSR_MAX_UNITS:   cfg_in.max_units   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format_mode <= 1'b0;
         cfg_ff.max_units   <= MAX_UNITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   wstu_front #(
      .MAX_BODY_BYTES(MAX_BODY_BYTES)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .cfg   (cfg_ff),
      .push  (q_push),
      .job   (q_job)
   );

   wstu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   wstu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // jobs only come from accepted transactions
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> take)
      else $error("job pushed without an accepted transaction");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STATUS_OK) |-> rsp_data.last)
      else $error("error result without last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> (rsp_data.out_byte == 8'd0))
      else $error("terminator byte is not zero");

endmodule

`default_nettype wire

FILE: sv/wstu_front.sv
// Front end: parses count bytes and body bytes, checks lengths, builds jobs.
// Depends on wstu_pkg.
`default_nettype none

module wstu_front #(
   parameter int MAX_BODY_BYTES = 65535
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire wstu_pkg::wstu_req_type req,
   input  wire wstu_pkg::wstu_cfg_type cfg,
   output logic                       push,
   output wstu_pkg::wstu_job_type     job
);
   import wstu_pkg::*;

   localparam logic [1:0] PH_LEN  = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   localparam logic [15:0] MaxBody = 16'(MAX_BODY_BYTES);

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  length_low_ff, length_low_in;
   logic [15:0] units_left_ff, units_left_in;
   logic [1:0]  byte_slot_ff, byte_slot_in;
   logic [31:0] code_point_ff, code_point_in;

   logic [15:0] left_c;
   logic [15:0] count16;
   logic [31:0] merged;
   logic        unit_done;
   logic [20:0] cp_sel;
   logic [15:0] units_dec;
   logic [1:0]  cp_len_m1;

   always_comb begin
      left_c  = (req.bytes_left > MaxBody) ? MaxBody : req.bytes_left;
      count16 = {req.data_byte, length_low_ff};
      merged  = code_point_ff | (32'(req.data_byte) << {byte_slot_ff, 3'b000});
      unit_done = cfg.format_mode ? (byte_slot_ff != 2'd0) : (byte_slot_ff == 2'd3);

      if (cfg.format_mode) begin
         if (merged[15:11] == 5'b11011) cp_sel = REPLACEMENT_CHAR;
         else                           cp_sel = {5'd0, merged[15:0]};
      end else begin
         if (merged >= CODE_POINT_LIMIT) cp_sel = REPLACEMENT_CHAR;
         else                            cp_sel = merged[20:0];
      end

      if (cp_sel < 21'h80)         cp_len_m1 = 2'd0;
      else if (cp_sel < 21'h800)   cp_len_m1 = 2'd1;
      else if (cp_sel < 21'h10000) cp_len_m1 = 2'd2;
      else                         cp_len_m1 = 2'd3;

      units_dec = (units_left_ff == 16'd0) ? 16'd0 : units_left_ff - 16'd1;
   end

   always_comb begin
      phase_in      = phase_ff;
      length_low_in = length_low_ff;
      units_left_in = units_left_ff;
      byte_slot_in  = byte_slot_ff;
      code_point_in = code_point_ff;
      push          = 1'b0;
      job           = '0;
      job.term      = 1'b1;
      job.status    = STATUS_OK;

      if (take) begin
         case (phase_ff)
            PH_HIGH: begin
               phase_in = PH_LEN;
               if (count16 > cfg.max_units) begin
                  push       = 1'b1;
                  job.status = STATUS_TOO_LONG;
               end else if ({1'b0, left_c} < {count16, 1'b0}) begin
                  push       = 1'b1;
                  job.status = STATUS_TRUNC;
               end else if (count16 == 16'd0) begin
                  push = 1'b1;
               end else begin
                  units_left_in = count16;
                  byte_slot_in  = 2'd0;
                  code_point_in = 32'd0;
                  phase_in      = PH_BODY;
               end
            end
            PH_BODY: begin
               if (!unit_done) begin
                  byte_slot_in  = byte_slot_ff + 2'd1;
                  code_point_in = merged;
               end else begin
                  push          = 1'b1;
                  job.has_char  = 1'b1;
                  job.len_m1    = cp_len_m1;
                  job.cp        = cp_sel;
                  job.term      = (units_dec == 16'd0);
                  code_point_in = 32'd0;
                  byte_slot_in  = 2'd0;
                  units_left_in = units_dec;
                  if (units_dec == 16'd0) phase_in = PH_LEN;
               end
            end
            default: begin
               // awaiting the first count byte
               phase_in = PH_LEN;
               if (cfg.format_mode) begin
                  if (left_c == 16'd0) begin
                     push       = 1'b1;
                     job.status = STATUS_TRUNC;
                  end else begin
                     length_low_in = req.data_byte;
                     phase_in      = PH_HIGH;
                  end
               end else if (left_c < {6'd0, req.data_byte, 2'b00}) begin
                  push       = 1'b1;
                  job.status = STATUS_TRUNC;
               end else if (req.data_byte == 8'd0) begin
                  push = 1'b1;
               end else begin
                  units_left_in = {8'd0, req.data_byte};
                  byte_slot_in  = 2'd0;
                  code_point_in = 32'd0;
                  phase_in      = PH_BODY;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         length_low_ff <= 8'd0;
         units_left_ff <= 16'd0;
         byte_slot_ff  <= 2'd0;
         code_point_ff <= 32'd0;
      end else begin
         phase_ff      <= phase_in;
         length_low_ff <= length_low_in;
         units_left_ff <= units_left_in;
         byte_slot_ff  <= byte_slot_in;
         code_point_ff <= code_point_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/wstu_queue.sv
// Short job queue between the parsing front end and the byte emitter.
// Depends on wstu_pkg.
`default_nettype none

module wstu_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire wstu_pkg::wstu_job_type push_data,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       head_valid,
   output wstu_pkg::wstu_job_type     head_data
);
   import wstu_pkg::*;

   wstu_job_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 do_push, do_pop;

   always_comb begin
      full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_data  = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

FILE: sv/wstu_back.sv
// Back end: expands queued jobs into UTF-8 bytes and end markers, one a cycle
// when rsp_ready allows, into the registered result stage. Depends on wstu_pkg.
`default_nettype none

module wstu_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire wstu_pkg::wstu_job_type head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output wstu_pkg::wstu_rsp_type     rsp_data
);
   import wstu_pkg::*;

   logic [2:0]    idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   wstu_rsp_type  rsp_data_ff, rsp_data_in;

   logic          load;
   logic [2:0]    total_m1;
   logic          is_char;
   logic [1:0]    sh;
   logic [5:0]    six;
   logic [7:0]    lead;
   logic [7:0]    char_byte;

   always_comb begin
      total_m1 = head.has_char ? ({1'b0, head.len_m1} + {2'b00, head.term}) : 3'd0;
      is_char  = head.has_char && (idx_ff <= {1'b0, head.len_m1});
      sh       = head.len_m1 - idx_ff[1:0];

      case (sh)
         2'd0:    six = head.cp[5:0];
         2'd1:    six = head.cp[11:6];
         2'd2:    six = head.cp[17:12];
         default: six = {3'b000, head.cp[20:18]};
      endcase

      case (head.len_m1)
         2'd0:    lead = {1'b0, head.cp[6:0]};
         2'd1:    lead = UTF8_LEAD2 | {3'b000, head.cp[10:6]};
         2'd2:    lead = UTF8_LEAD3 | {4'b0000, head.cp[15:12]};
         default: lead = UTF8_LEAD4 | {5'b00000, head.cp[20:18]};
      endcase

      char_byte = (idx_ff == 3'd0) ? lead : (UTF8_CONT | {2'b00, six});

      load = head_valid && (!rsp_valid_ff || rsp_ready);
      pop  = load && (idx_ff == total_m1);

      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (is_char) begin
            rsp_data_in.out_byte = char_byte;
            rsp_data_in.last     = 1'b0;
            rsp_data_in.status   = STATUS_OK;
         end else begin
            rsp_data_in.out_byte = 8'd0;
            rsp_data_in.last     = 1'b1;
            rsp_data_in.status   = head.status;
         end
         idx_in = pop ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: tb/sv/wire_string_to_utf8_top_tb.sv
// Self-checking testbench for wire_string_to_utf8_top: directed strings, then random phases.
// Keeps its own model of the count/body parser and the UTF-8 encoder to predict each result.
// Depends on wstu_pkg and wire_string_to_utf8_top.
`default_nettype none

module wire_string_to_utf8_top_tb;
   import wstu_pkg::*;

   localparam int BODY_LIMIT    = 65535;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 30;

   typedef enum logic [1:0] {
      PARSE_COUNT      = 2'd0,
      PARSE_COUNT_HIGH = 2'd1,
      PARSE_BODY       = 2'd2
   } parse_phase_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   wstu_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   wstu_rsp_type rsp_data;
   logic         csr_we    = 1'b0;
   logic         csr_index = CSR_FORMAT_MODE;
   logic [15:0]  csr_wdata = 16'd0;

   // transcoder model: configuration and parser state
   logic            cfg_mode        = 1'b0;
   logic [15:0]     cfg_max_units   = MAX_UNITS_RESET;
   parse_phase_type parse_phase     = PARSE_COUNT;
   logic [7:0]      count_low       = 8'd0;
   logic [15:0]     units_remaining = 16'd0;
   logic [1:0]      slot            = 2'd0;
   logic [31:0]     cp_accum        = 32'd0;

   wstu_req_type tx_bytes[$];
   wstu_rsp_type utf8_expected[$];

   bit send_fired    = 1'b0;
   int send_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int mismatches    = 0;
   int cycle_count   = 0;
   int n_bytes_in    = 0;
   int n_bytes_out   = 0;
   int n_closed      = 0;
   int n_trunc       = 0;
   int n_over        = 0;

   wire_string_to_utf8_top #(
      .MAX_BODY_BYTES(BODY_LIMIT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, utf8_expected.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   function automatic void push_result(logic [7:0] b, logic fin, logic [1:0] st);
      wstu_rsp_type r;
      r.out_byte = b;
      r.last     = fin;
      r.status   = st;
      utf8_expected.push_back(r);
   endfunction

   function automatic void push_utf8(logic [31:0] cp);
      if (cp < 32'h80) begin
         push_result(cp[7:0], 1'b0, STATUS_OK);
      end else if (cp < 32'h800) begin
         push_result(UTF8_LEAD2 | {3'd0, cp[10:6]}, 1'b0, STATUS_OK);
         push_result(UTF8_CONT | {2'd0, cp[5:0]}, 1'b0, STATUS_OK);
      end else if (cp < 32'h10000) begin
         push_result(UTF8_LEAD3 | {4'd0, cp[15:12]}, 1'b0, STATUS_OK);
         push_result(UTF8_CONT | {2'd0, cp[11:6]}, 1'b0, STATUS_OK);
         push_result(UTF8_CONT | {2'd0, cp[5:0]}, 1'b0, STATUS_OK);
      end else begin
         push_result(UTF8_LEAD4 | {5'd0, cp[20:18]}, 1'b0, STATUS_OK);
         push_result(UTF8_CONT | {2'd0, cp[17:12]}, 1'b0, STATUS_OK);
         push_result(UTF8_CONT | {2'd0, cp[11:6]}, 1'b0, STATUS_OK);
         push_result(UTF8_CONT | {2'd0, cp[5:0]}, 1'b0, STATUS_OK);
      end
   endfunction

   function automatic void open_body(logic [15:0] n);
      units_remaining = n;
      slot            = 2'd0;
      cp_accum        = 32'd0;
      parse_phase     = PARSE_BODY;
   endfunction

   // advance the parser model by one accepted byte and queue what it should emit
   function automatic void predict_utf8(wstu_req_type t);
      int unsigned left;
      int unsigned count;
      logic [31:0] cp;
      logic        unit_done;
      left = t.bytes_left;
      if (left > BODY_LIMIT)
         left = BODY_LIMIT;
      case (parse_phase)
         PARSE_COUNT_HIGH: begin
            count       = {t.data_byte, count_low};
            parse_phase = PARSE_COUNT;
            if (count > cfg_max_units)
               push_result(8'd0, 1'b1, STATUS_TOO_LONG);
            else if (left < count * 2)
               push_result(8'd0, 1'b1, STATUS_TRUNC);
            else if (count == 0)
               push_result(8'd0, 1'b1, STATUS_OK);
            else
               open_body(count[15:0]);
         end
         PARSE_BODY: begin
            cp_accum  = cp_accum | ({24'd0, t.data_byte} << (8 * slot));
            unit_done = cfg_mode ? (slot >= 2'd1) : (slot == 2'd3);
            if (!unit_done) begin
               slot = slot + 2'd1;
            end else begin
               cp = cp_accum;
               if (cfg_mode) begin
                  cp = cp & 32'h0000_FFFF;
                  if (cp >= 32'hD800 && cp <= 32'hDFFF)
                     cp = 32'(REPLACEMENT_CHAR);
               end else if (cp >= CODE_POINT_LIMIT) begin
                  cp = 32'(REPLACEMENT_CHAR);
               end
               push_utf8(cp);
               cp_accum = 32'd0;
               slot     = 2'd0;
               if (units_remaining > 0)
                  units_remaining--;
               if (units_remaining == 0) begin
                  push_result(8'd0, 1'b1, STATUS_OK);
                  parse_phase = PARSE_COUNT;
               end
            end
         end
         default: begin
            parse_phase = PARSE_COUNT;
            if (cfg_mode) begin
               if (left < 1) begin
                  push_result(8'd0, 1'b1, STATUS_TRUNC);
               end else begin
                  count_low   = t.data_byte;
                  parse_phase = PARSE_COUNT_HIGH;
               end
            end else if (left < t.data_byte * 4) begin
               push_result(8'd0, 1'b1, STATUS_TRUNC);
            end else if (t.data_byte == 0) begin
               push_result(8'd0, 1'b1, STATUS_OK);
            end else begin
               open_body({8'd0, t.data_byte});
            end
         end
      endcase
   endfunction

   // request driver: a new transaction only once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || send_fired) begin
            if (tx_bytes.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               req_data  <= tx_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor: predict on every accepted request, check every accepted result
   always @(posedge clock) begin
      wstu_rsp_type want;
      send_fired = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_utf8(req_data);
            send_fired = 1'b1;
            n_bytes_in++;
         end
         if (rsp_valid && rsp_ready) begin
            n_bytes_out++;
            if (rsp_data.last) begin
               if (rsp_data.status == STATUS_TRUNC)
                  n_trunc++;
               else if (rsp_data.status == STATUS_TOO_LONG)
                  n_over++;
               else
                  n_closed++;
            end
            if (utf8_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte %02h last %0d status %0d",
                                         rsp_data.out_byte, rsp_data.last, rsp_data.status));
            end else begin
               want = utf8_expected.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_data.out_byte, want.out_byte));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last %0d, want %0d (byte %02h)",
                                            rsp_data.last, want.last, want.out_byte));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_data.status, want.status));
            end
         end
      end
   end

   function automatic void push_req(logic [7:0] b, logic [15:0] left);
      wstu_req_type t;
      t.data_byte  = b;
      t.bytes_left = left;
      tx_bytes.push_back(t);
   endfunction

   function automatic logic [15:0] clamp_left(int v);
      if (v < 0)
         return 16'd0;
      if (v > 65535)
         return 16'hFFFF;
      return 16'(v);
   endfunction

   // one string under the current mode; short_by trims the advertised body length
   task automatic queue_string(int units, int short_by);
      int          body_len;
      int          pos;
      int          u;
      int          j;
      bit          ok;
      logic [31:0] cp;
      body_len = cfg_mode ? 2 * units : 4 * units;
      ok = (short_by == 0) && (units > 0) && (!cfg_mode || units <= cfg_max_units);
      if (cfg_mode) begin
         push_req(units[7:0], clamp_left(body_len + 1));
         push_req(units[15:8], clamp_left(body_len - short_by));
      end else begin
         push_req(units[7:0], clamp_left(body_len - short_by));
      end
      pos = 0;
      if (ok) begin
         for (u = 0; u < units; u++) begin
            if (cfg_mode) begin
               case ($urandom_range(4))
                  0: cp = $urandom_range(32'h7F);
                  1: cp = $urandom_range(32'h80, 32'h7FF);
                  2: cp = $urandom_range(32'h800, 32'hFFFF);
                  3: cp = $urandom_range(32'hD800, 32'hDFFF);
                  default: cp = $urandom_range(32'hFFFF);
               endcase
            end else begin
               case ($urandom_range(6))
                  0: cp = $urandom_range(32'h7F);
                  1: cp = $urandom_range(32'h80, 32'h7FF);
                  2: cp = $urandom_range(32'h800, 32'hFFFF);
                  3: cp = $urandom_range(32'hD800, 32'hDFFF);
                  4: cp = $urandom_range(32'h10000, 32'h10FFFF);
                  5: cp = $urandom_range(32'h110000, 32'hFFFFFFFF);
                  default: cp = $urandom();
               endcase
            end
            for (j = 0; j < (cfg_mode ? 2 : 4); j++) begin
               pos++;
               // body bytes_left is not checked by the block, so scramble it sometimes
               push_req(cp[8*j +: 8], ($urandom_range(3) == 0) ? 16'($urandom())
                                                                : clamp_left(body_len - pos));
            end
         end
      end
   endtask

   task automatic queue_random(int target);
      int base;
      int pick;
      int units;
      base = tx_bytes.size();
      while (tx_bytes.size() - base < target) begin
         pick  = $urandom_range(99);
         units = cfg_mode ? $urandom_range(1, 6) : $urandom_range(1, 4);
         if (pick < 10) begin
            // stray bytes; keep counts small when the length would pass
            if ($urandom_range(7) == 0)
               push_req(8'($urandom_range(3)), 16'($urandom_range(16'hFFFF)));
            else
               push_req(8'($urandom_range(255)), 16'($urandom_range(3)));
         end else if (pick < 15) begin
            queue_string(0, 0);
         end else if (pick < 80) begin
            queue_string(units, 0);
         end else if (pick < 90 || !cfg_mode || cfg_max_units == 16'hFFFF) begin
            queue_string(units, $urandom_range(1, 2 * units));
         end else begin
            units = int'(cfg_max_units) + $urandom_range(1, 300);
            if (units > 65535)
               units = 65535;
            queue_string(units, 0);
         end
      end
   endtask

   // block is idle: all stimulus taken, all results seen, plus the pipeline latency
   task automatic wait_idle();
      while (tx_bytes.size() != 0 || req_valid || utf8_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FORMAT_MODE)
         cfg_mode = value[0];
      else
         cfg_max_units = value;
   endtask

   task automatic run_phase(logic mode, logic [15:0] cap, int gap, int stall, int target);
      write_csr(CSR_FORMAT_MODE, {15'd0, mode});
      write_csr(CSR_MAX_UNITS, cap);
      send_gap_pct  = gap;
      rsp_stall_pct = stall;
      queue_random(target);
      wait_idle();
   endtask

   initial begin
      int i;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // byte-count mode at reset values: empty string, short body, out-of-range code point
      push_req(8'd0, 16'd0);
      push_req(8'hFF, 16'd0);
      push_req(8'd1, 16'hFFFF);
      for (i = 3; i >= 0; i--)
         push_req(8'hFF, 16'(i));
      wait_idle();

      write_csr(CSR_FORMAT_MODE, 16'd1);
      push_req(8'd5, 16'd0);                            // count byte with nothing behind it
      push_req(8'd0, 16'd1);
      push_req(8'd0, 16'd0);                            // empty string
      push_req(8'hFF, 16'hFFFF);
      push_req(8'hFF, 16'hFFFF);                        // over the cap and short: cap wins
      push_req(8'd2, 16'd5);
      push_req(8'd0, 16'd4);
      push_req(8'hFF, 16'd3);
      push_req(8'hDF, 16'd2);                           // lone surrogate
      push_req(8'hFF, 16'd1);
      push_req(8'h07, 16'd0);                           // top of the two-byte range
      push_req(8'd1, 16'd3);
      push_req(8'd0, 16'd2);
      push_req(8'd0, 16'd1);                            // first byte of a unit, then switch
      wait_idle();
      write_csr(CSR_FORMAT_MODE, 16'd0);
      push_req(8'd0, 16'd2);
      push_req(8'h01, 16'd1);
      push_req(8'd0, 16'd0);                            // completes U+10000 as a 32-bit unit
      wait_idle();

      run_phase(1'b0, MAX_UNITS_RESET, 0, 0, 50);
      run_phase(1'b1, 16'hFFFF, 80, 0, 50);
      run_phase(1'b1, 16'd3, 0, 80, 45);
      run_phase(1'b0, 16'd0, 11, 11, 45);
      run_phase(1'b1, 16'd0, 0, 0, 20);
      run_phase(1'b1, 16'd1000, 11, 11, 50);
      run_phase(1'b0, 16'hFFFF, 80, 80, 20);

      if (utf8_expected.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", utf8_expected.size()));
      $display("Covered %0d input bytes in both count formats, caps 0 to 65535, with idling",
               n_bytes_in);
      $display("Checked %0d output bytes: %0d strings closed, %0d truncated, %0d over cap",
               n_bytes_out, n_closed, n_trunc, n_over);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
sv/wstu_pkg.sv
sv/wstu_front.sv
sv/wstu_queue.sv
sv/wstu_back.sv
sv/wire_string_to_utf8_top.sv
tb/sv/wire_string_to_utf8_top_tb.sv
